[rtl/core/plsb_pkg.sv]
`timescale 1ns / 1ps

package plsb_pkg;

    // Ring geometry default
    localparam int RING_DEPTH_DEF = 64;

    // Field widths
    localparam int TIME_W = 32;
    localparam int PAY_W  = 64;
    localparam int CNT32_W = 32;
    localparam int PERIOD_W = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_SAMPLE_PERIOD = 1'b0;

    // Input item actions
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_PEEK   = 2'd1;
    localparam logic [1:0] ACT_COMMIT = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    // Sample update status codes
    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_CLOSED   = 2'd1;
    localparam logic [1:0] ST_OPENED   = 2'd2;
    localparam logic [1:0] ST_APPENDED = 2'd3;

    // One ring record
    typedef struct packed {
        logic             endf;
        logic [PAY_W-1:0] data;
        logic [TIME_W-1:0] utc;
    } t_rec;

endpackage

[rtl/core/plsb_ring.sv]
`timescale 1ns / 1ps

module plsb_ring
    import plsb_pkg::*;
#(
    parameter int DEPTH = RING_DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_rec             i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output t_rec             o_rdata
);

    t_rec r_mem [DEPTH];
    t_rec r_rdata;

    // Write one record, read one record; a read of the slot being written
    // returns the new record
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/pretrigger_session_log_buffer.sv]
`timescale 1ns / 1ps

// Pre-trigger session log buffer. Keeps a ring of RING_DEPTH records (time
// stamp, payload, end flag) that turns over on the ground and is drained by
// peek/commit items once a flight session opens. The block takes one item
// per clock while the result side is not stalled: an item sits in the input
// register, where all the control work and the ring access (a write, a read,
// or both when a session opens) happen, and its result is then loaded into
// the output register; the ring memory port sets the rate of one item per
// cycle. The ring contents need no clearing after reset; only held records
// are ever read. sample_period_ms is register 0 at byte address 0 of the
// configuration port.
module pretrigger_session_log_buffer
    import plsb_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [2:0] flying, fix_ok, time_valid; [34:3] now_ms;
    // [66:35] sample_utc; [130:67] sample_payload; [135:131] zero
    input  logic [135:0]          s_axis_tdata,
    // [1:0] action
    input  logic [1:0]            s_axis_tuser,

    // Result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] update_status; [2] record_valid; [34:3] record_utc;
    // [98:35] record_payload; [130:99] session_name; [162:131] drop_total;
    // [163] session_open; [167:164] zero
    output logic [167:0]          m_axis_tdata,
    // record_end
    output logic                  m_axis_tlast,

    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(RING_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        idx_inc = (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    // Input register
    logic                r_in_valid;
    logic [1:0]          r_in_action;
    logic                r_in_flying;
    logic                r_in_fix;
    logic                r_in_time;
    logic [TIME_W-1:0]   r_in_now;
    logic [TIME_W-1:0]   r_in_utc;
    logic [PAY_W-1:0]    r_in_pay;

    // Result register
    logic                r_out_valid;
    logic [1:0]          r_out_status;
    logic                r_out_rec_valid;

    // Session state
    logic [IDX_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_held, n_held;
    logic [CNT_W-1:0]    r_flush, n_flush;
    logic [TIME_W-1:0]   r_name, n_name;
    logic                r_name_in_rd, n_name_in_rd;
    logic [CNT32_W-1:0]  r_drops, n_drops;
    logic [TIME_W-1:0]   r_last, n_last;
    logic                r_has, n_has;
    logic                r_open, n_open;
    logic                r_closing, n_closing;
    logic [PERIOD_W-1:0] r_period;

    logic [1:0]          n_status;
    logic                n_rec_valid;

    logic                advance;
    logic                mem_we, mem_re;
    logic [IDX_W-1:0]    mem_raddr;
    t_rec                mem_wdata, mem_rdata;

    // Push helpers
    logic                full;
    logic [IDX_W-1:0]    p_head;
    logic [CNT_W-1:0]    p_held1, p_held, p_flush;
    logic [CNT_W:0]      p_sum;
    logic [IDX_W-1:0]    p_slot;
    logic [CNT32_W-1:0]  p_drops;
    logic [TIME_W-1:0]   eff_name;
    logic [TIME_W-1:0]   since_last;
    logic                usable, early, landing;
    logic [CNT_W-1:0]    c_flush;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Latch an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_action <= s_axis_tuser;
            r_in_flying <= s_axis_tdata[0];
            r_in_fix    <= s_axis_tdata[1];
            r_in_time   <= s_axis_tdata[2];
            r_in_now    <= s_axis_tdata[34:3];
            r_in_utc    <= s_axis_tdata[66:35];
            r_in_pay    <= s_axis_tdata[130:67];
        end
    end

    // Overwrite-on-full push: make room, then append at head + held
    always_comb begin
        full    = (r_held == DEPTH_C);
        p_head  = full ? idx_inc(r_head) : r_head;
        p_held1 = full ? DEPTH_C - 1'b1 : r_held;
        p_sum   = {1'b0, CNT_W'(p_head)} + {1'b0, p_held1};
        if (p_sum >= {1'b0, DEPTH_C}) begin
            p_sum = p_sum - {1'b0, DEPTH_C};
        end
        p_slot  = p_sum[IDX_W-1:0];
        p_held  = p_held1 + 1'b1;
        p_drops = r_drops + CNT32_W'(full && (r_open || r_closing));
        p_flush = (full && (r_flush != '0)) ? r_flush - 1'b1 : r_flush;
    end

    assign eff_name   = r_name_in_rd ? mem_rdata.utc : r_name;
    assign since_last = r_in_now - r_last;
    assign usable     = r_in_fix && r_in_time;
    assign early      = r_has && (since_last < {16'b0, r_period});
    assign landing    = r_open && !r_in_flying;

    assign mem_wdata.utc  = r_in_utc;
    assign mem_wdata.data = r_in_pay;
    assign mem_wdata.endf = landing;

    // Work out the next session state for the item in the input register
    always_comb begin
        n_head       = r_head;
        n_held       = r_held;
        n_flush      = r_flush;
        n_name       = eff_name;
        n_name_in_rd = 1'b0;
        n_drops      = r_drops;
        n_last       = r_last;
        n_has        = r_has;
        n_open       = r_open;
        n_closing    = r_closing;
        n_status     = ST_IDLE;
        n_rec_valid  = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_raddr    = r_head;
        c_flush      = (r_flush != '0) ? r_flush - 1'b1 : r_flush;

        unique case (r_in_action)
            ACT_SAMPLE: begin
                if (landing) begin
                    // Close the session; an end record goes in only if usable
                    if (usable) begin
                        mem_we  = 1'b1;
                        n_head  = p_head;
                        n_held  = p_held;
                        n_drops = p_drops;
                        n_flush = p_held;
                    end else begin
                        n_flush = r_held;
                    end
                    n_open    = 1'b0;
                    n_closing = 1'b1;
                    n_status  = ST_CLOSED;
                end else if (usable && !early) begin
                    n_last  = r_in_now;
                    n_has   = 1'b1;
                    mem_we  = 1'b1;
                    n_head  = p_head;
                    n_held  = p_held;
                    n_drops = p_drops;
                    n_flush = p_flush;
                    if (r_open) begin
                        n_status = ST_APPENDED;
                    end else if (r_in_flying) begin
                        // Name the session after the oldest held record
                        mem_re       = 1'b1;
                        mem_raddr    = p_head;
                        n_name_in_rd = 1'b1;
                        n_open       = 1'b1;
                        n_closing    = 1'b0;
                        n_status     = ST_OPENED;
                    end
                end
            end
            ACT_PEEK: begin
                if ((!r_open && (r_flush == '0)) || (r_held == '0)) begin
                    n_closing = 1'b0;
                end else begin
                    mem_re      = 1'b1;
                    n_rec_valid = 1'b1;
                end
            end
            ACT_COMMIT: begin
                if (r_held != '0) begin
                    n_head  = idx_inc(r_head);
                    n_held  = r_held - 1'b1;
                    n_flush = c_flush;
                    if (!r_open && (c_flush == '0)) begin
                        n_closing = 1'b0;
                    end
                end
            end
            ACT_CLEAR: begin
                n_head    = '0;
                n_held    = '0;
                n_flush   = '0;
                n_name    = '0;
                n_has     = 1'b0;
                n_open    = 1'b0;
                n_closing = 1'b0;
            end
            default: begin
                n_status = ST_IDLE;
            end
        endcase
    end

    plsb_ring #(
        .DEPTH (RING_DEPTH),
        .IDX_W (IDX_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (mem_we && advance),
        .i_waddr (p_slot),
        .i_wdata (mem_wdata),
        .i_re    (mem_re && advance),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Commit the step and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_head       <= '0;
            r_held       <= '0;
            r_flush      <= '0;
            r_name       <= '0;
            r_name_in_rd <= 1'b0;
            r_drops      <= '0;
            r_last       <= '0;
            r_has        <= 1'b0;
            r_open       <= 1'b0;
            r_closing    <= 1'b0;
        end else if (advance) begin
            r_out_valid  <= 1'b1;
            r_head       <= n_head;
            r_held       <= n_held;
            r_flush      <= n_flush;
            r_name       <= n_name;
            r_name_in_rd <= n_name_in_rd;
            r_drops      <= n_drops;
            r_last       <= n_last;
            r_has        <= n_has;
            r_open       <= n_open;
            r_closing    <= n_closing;
        end else if (m_axis_tready) begin
            r_out_valid  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_status    <= n_status;
            r_out_rec_valid <= n_rec_valid;
        end
    end

    // Drive the result item; record fields read zero unless a peek hit
    assign m_axis_tvalid         = r_out_valid;
    assign m_axis_tdata[1:0]     = r_out_status;
    assign m_axis_tdata[2]       = r_out_rec_valid;
    assign m_axis_tdata[34:3]    = r_out_rec_valid ? mem_rdata.utc : '0;
    assign m_axis_tdata[98:35]   = r_out_rec_valid ? mem_rdata.data : '0;
    assign m_axis_tdata[130:99]  = eff_name;
    assign m_axis_tdata[162:131] = r_drops;
    assign m_axis_tdata[163]     = r_open;
    assign m_axis_tdata[167:164] = 4'b0;
    assign m_axis_tlast          = r_out_rec_valid && mem_rdata.endf;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[APB_ADDR_W-1:2] == REG_SAMPLE_PERIOD)) begin
            r_period <= pwdata[PERIOD_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_SAMPLE_PERIOD) ?
                    {{(APB_DATA_W-PERIOD_W){1'b0}}, r_period} : '0;

endmodule
